FILE: hdl/bcd_pkg.sv
// Shared types and constants of the button chain debouncer.
package bcd_pkg;

	localparam int LANES           = 8;
	localparam int MAX_BUTTONS_DEF = 104;
	localparam int ROW_FIELD_W     = 5;   // holds a row index for up to 256 buttons
	localparam int CNT_W           = 9;   // button counts and flat button indexes
	localparam int CFG_ADDR_W      = 2;
	localparam int CFG_DATA_W      = 8;

	localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LOW     = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BUTTON_COUNT   = 2'd2;

	localparam logic [7:0] TICKS_RESET      = 8'd10;
	localparam logic       ACTIVE_LOW_RESET = 1'b1;
	localparam logic [6:0] COUNT_RESET      = 7'd10;

	typedef struct packed {
		logic [7:0] chain_byte;
		logic       scan_start;
	} item_t;

	typedef struct packed {
		logic [3:0] byte_position;
		logic [7:0] stable_levels;
		logic [7:0] press_mask;
		logic [7:0] release_mask;
	} result_t;

	// classified request handed from the front to the back
	typedef struct packed {
		logic [ROW_FIELD_W-1:0] row;
		logic [LANES-1:0]       pressed;
		logic [LANES-1:0]       use_mask;
		logic                   primed;
	} op_t;

endpackage

FILE: hdl/bcd_fifo.sv
// Small register queue used between stages and at the result side.
module bcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not grow on push");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("queue count did not shrink on pop");

endmodule

FILE: hdl/bcd_front.sv
// Front part: configuration registers, chain position tracking and lane classification.
module bcd_front import bcd_pkg::*; #(
	parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  accept,
	input  item_t                 item,
	output op_t                   op,
	output logic [7:0]            ticks
);

	localparam int ROWS  = (MAX_BUTTONS + LANES - 1) / LANES;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [7:0]       ticks_q;
	logic             active_low_q;
	logic [6:0]       button_count_q;
	logic [ROW_W-1:0] cursor_q;
	logic             primed_q;

	logic [CNT_W-1:0] count, nbytes_raw, nbytes, pos_ext;
	logic [ROW_W-1:0] pos_raw, pos;
	logic             last;
	logic [LANES-1:0] use_mask;

	always_comb begin
		count = (CNT_W'(button_count_q) > CNT_W'(MAX_BUTTONS)) ?
			CNT_W'(MAX_BUTTONS) : CNT_W'(button_count_q);
		nbytes_raw = (count + CNT_W'(LANES - 1)) >> 3;
		nbytes     = (nbytes_raw == '0) ? CNT_W'(1) : nbytes_raw;
		pos_raw    = item.scan_start ? '0 : cursor_q;
		// cursor left past the chain end after a shorter chain was set
		pos        = (CNT_W'(pos_raw) >= nbytes) ? '0 : pos_raw;
		pos_ext    = CNT_W'(pos);
		last       = (pos_ext == nbytes - 1'b1);
		for (int b = 0; b < LANES; b++) begin
			use_mask[b] = ((pos_ext << 3) + CNT_W'(b)) < count;
		end
	end

	assign op.row      = ROW_FIELD_W'(pos);
	assign op.pressed  = active_low_q ? ~item.chain_byte : item.chain_byte;
	assign op.use_mask = use_mask;
	assign op.primed   = primed_q;
	assign ticks       = ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q        <= TICKS_RESET;
			active_low_q   <= ACTIVE_LOW_RESET;
			button_count_q <= COUNT_RESET;
			cursor_q       <= '0;
			primed_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_DEBOUNCE_TICKS: ticks_q        <= cfg_wdata;
					REG_ACTIVE_LOW:     active_low_q   <= cfg_wdata[0];
					REG_BUTTON_COUNT:   button_count_q <= cfg_wdata[6:0];
					default: ;
				endcase
			end
			if (accept) begin
				cursor_q <= last ? '0 : pos + 1'b1;
				if (last) begin
					primed_q <= 1'b1;
				end
			end
		end
	end

	a_pos_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (pos_ext < nbytes))
		else $error("position outside the chain");
	a_start_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.scan_start) |-> (pos == '0))
		else $error("scan start did not resync position");
	a_primed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(primed_q) |-> primed_q)
		else $error("primed flag dropped");

endmodule

FILE: hdl/bcd_back.sv
// Back part: per-button settle counters and stable levels, eight lanes per row.
module bcd_back import bcd_pkg::*; #(
	parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ticks,
	input  logic       op_valid,
	input  op_t        op,
	output logic       op_take,
	input  logic       res_full,
	output logic       res_push,
	output result_t    res
);

	localparam int ROWS  = (MAX_BUTTONS + LANES - 1) / LANES;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [LANES-1:0]            stable_q [ROWS];
	logic [LANES-1:0][7:0]       cnt_q    [ROWS];
	logic [ROW_W-1:0]            row;
	logic                        do_op;
	logic [LANES-1:0]            cur_s, new_s, press, release_m;
	logic [LANES-1:0][7:0]       cur_c, new_c, inc_c;

	assign row      = op.row[ROW_W-1:0];
	assign do_op    = op_valid && !res_full;
	assign op_take  = do_op;
	assign res_push = do_op;
	assign cur_s    = stable_q[row];
	assign cur_c    = cnt_q[row];

	always_comb begin
		for (int b = 0; b < LANES; b++) begin
			new_s[b]     = cur_s[b];
			new_c[b]     = cur_c[b];
			press[b]     = 1'b0;
			release_m[b] = 1'b0;
			// saturating count; a zero tick setting behaves as one
			inc_c[b]     = (cur_c[b] < ticks) ? cur_c[b] + 8'd1 : cur_c[b];
			if (op.use_mask[b]) begin
				if (!op.primed) begin
					new_s[b] = op.pressed[b];
					new_c[b] = '0;
				end else if (op.pressed[b] == cur_s[b]) begin
					new_c[b] = '0;
				end else if (inc_c[b] >= ticks) begin
					new_s[b]     = op.pressed[b];
					new_c[b]     = '0;
					press[b]     = op.pressed[b];
					release_m[b] = !op.pressed[b];
				end else begin
					new_c[b] = inc_c[b];
				end
			end
		end
	end

	assign res.byte_position = 4'(op.row);
	assign res.stable_levels = new_s & op.use_mask;
	assign res.press_mask    = press;
	assign res.release_mask  = release_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				stable_q[r] <= '0;
				cnt_q[r]    <= '0;
			end
		end else if (do_op) begin
			stable_q[row] <= new_s;
			cnt_q[row]    <= new_c;
		end
	end

	a_no_double_event: assert property (@(posedge clk) disable iff (!arst_n)
		do_op |-> ((press & release_m) == '0))
		else $error("press and release on one lane");
	a_events_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		do_op |-> (((press | release_m) & ~op.use_mask) == '0))
		else $error("event on an unused lane");
	a_quiet_priming: assert property (@(posedge clk) disable iff (!arst_n)
		(do_op && !op.primed) |-> ((press | release_m) == '0))
		else $error("event during priming scan");
	a_row_written: assert property (@(posedge clk) disable iff (!arst_n)
		do_op |=> (stable_q[$past(row)] == $past(new_s)))
		else $error("row update lost");

endmodule

FILE: hdl/button_chain_debouncer_unit.sv
// Top level of the button chain debouncer: front, request queue, back, result queue.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  input    | push / full        | item   : chain_byte, scan_start
//  result   | pop / empty        | result : byte_position, stable_levels, masks
//  config   | cfg_we             | cfg_addr (register index), cfg_wdata
//
// One request per clock while results drain; request and result each pass a queue.
// The back updates one row (eight counters and stable bits) per cycle unless stalled.
// Reset clears counters, stable levels, position and priming at once; no clearing pass.
// Each side stalls on its own through the two-entry queues; full rises only when
// the back is held up by a full result queue.
module button_chain_debouncer_unit import bcd_pkg::*; #(
	parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	output logic                  full,
	input  item_t                 item,
	input  logic                  pop,
	output logic                  empty,
	output result_t               result
);

	op_t        op_in, op_out;
	result_t    res;
	logic [7:0] ticks;
	logic       accept, op_empty, op_take, res_full, res_push;

	assign accept = push && !full;

	bcd_front #(.MAX_BUTTONS(MAX_BUTTONS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (item),
		.op        (op_in),
		.ticks     (ticks)
	);

	bcd_fifo #(.WIDTH($bits(op_t)), .DEPTH(2)) u_op_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (op_in),
		.full   (full),
		.pop    (op_take),
		.rdata  (op_out),
		.empty  (op_empty)
	);

	bcd_back #(.MAX_BUTTONS(MAX_BUTTONS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ticks    (ticks),
		.op_valid (!op_empty),
		.op       (op_out),
		.op_take  (op_take),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	bcd_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
